// ----- hw/rtl/gf3_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gf3_pkg: shared constants and types of the 3x3 Gaussian image filter.
// Sizes of pixels, rows and columns, configuration register indexes and the
// per-pixel job descriptor passed from the line-store stage to the emitter.
// ----------------------------------------------------------------------------
package gf3_pkg;

	// Pixel and image geometry.
	localparam int PIX_W      = 8;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int SUM_W      = PIX_W + 4;

	// Configuration register port.
	localparam int HCFG_W     = 13;
	localparam int WCFG_W     = 11;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd1;

	// Up to three results that one input pixel releases.
	typedef struct packed {
		logic             emit_win;   // window centre (row-1, col-1)
		logic             emit_edge;  // right border (row-1, last column)
		logic             emit_bot;   // bottom border (row, col)
		logic             interior;   // window centre is an interior pixel
		logic             last;       // final pixel of a row; marks the frame end on its bottom result
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} job_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gf3_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gf3_ram: generic single-write, single-read synchronous RAM.
// The read data is registered and only updates when a read is enabled.
// ----------------------------------------------------------------------------
module gf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/gf3_linebuf.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gf3_linebuf: line stores, 3x3 window and kernel sum.
// Two column-addressed line stores hold the previous two rows. They are read
// when a pixel is accepted and written back when the pixel shifts into the
// window, one entry per transfer.
// ----------------------------------------------------------------------------
module gf3_linebuf (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            rd_en,
	input  wire [gf3_pkg::COL_W-1:0]       rd_addr,
	input  wire                            shift,
	input  wire [gf3_pkg::COL_W-1:0]       wr_addr,
	input  wire [gf3_pkg::PIX_W-1:0]       pix_s1,
	input  wire                            clear,
	output logic [gf3_pkg::PIX_W-1:0]      filt
);

	logic [gf3_pkg::PIX_W-1:0] up_rd;
	logic [gf3_pkg::PIX_W-1:0] lo_rd;
	logic [gf3_pkg::PIX_W-1:0] win_q [3][3];
	logic [gf3_pkg::SUM_W-1:0] sum;

	// Upper store takes what the lower store held; lower store takes the new pixel.
	gf3_ram #(
		.WIDTH (gf3_pkg::PIX_W),
		.DEPTH (gf3_pkg::MAX_WIDTH)
	) u_upper (
		.clk   (clk),
		.we    (shift),
		.waddr (wr_addr),
		.wdata (lo_rd),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (up_rd)
	);

	gf3_ram #(
		.WIDTH (gf3_pkg::PIX_W),
		.DEPTH (gf3_pkg::MAX_WIDTH)
	) u_lower (
		.clk   (clk),
		.we    (shift),
		.waddr (wr_addr),
		.wdata (pix_s1),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (lo_rd)
	);

	// Window shift: the newest column enters on the right.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (clear) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (shift) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= up_rd;
			win_q[1][2] <= lo_rd;
			win_q[2][2] <= pix_s1;
		end
	end

	// Kernel 1-2-1 / 2-4-2 / 1-2-1, then divide by sixteen.
	always_comb begin
		sum = gf3_pkg::SUM_W'(win_q[0][0]) + gf3_pkg::SUM_W'(win_q[0][2])
			+ gf3_pkg::SUM_W'(win_q[2][0]) + gf3_pkg::SUM_W'(win_q[2][2])
			+ (gf3_pkg::SUM_W'(win_q[0][1]) << 1) + (gf3_pkg::SUM_W'(win_q[1][0]) << 1)
			+ (gf3_pkg::SUM_W'(win_q[1][2]) << 1) + (gf3_pkg::SUM_W'(win_q[2][1]) << 1)
			+ (gf3_pkg::SUM_W'(win_q[1][1]) << 2);
		filt = sum[gf3_pkg::SUM_W-1:4];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/gf3_emit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gf3_emit: result serialiser and output register.
// Holds the results one pixel released and hands them to the output register
// one per cycle while the output is not stalled, in the order window centre,
// right border, bottom border.
module gf3_emit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            load,
	input  wire gf3_pkg::job_t             job_s1,
	input  wire [gf3_pkg::PIX_W-1:0]       filt,
	output logic                           done,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [gf3_pkg::PIX_W-1:0]      pixel_out,
	output logic [gf3_pkg::ROW_W-1:0]      out_row,
	output logic [gf3_pkg::COL_W-1:0]      out_col,
	output logic                           frame_last
);

	logic [2:0]                pend_q;
	logic                      interior_s2;
	logic                      last_s2;
	logic [gf3_pkg::ROW_W-1:0] row_s2;
	logic [gf3_pkg::COL_W-1:0] col_s2;
	logic                      out_free;
	logic                      take;
	logic [2:0]                pend_next;
	logic [gf3_pkg::PIX_W-1:0] sel_pix;
	logic [gf3_pkg::ROW_W-1:0] sel_row;
	logic [gf3_pkg::COL_W-1:0] sel_col;
	logic                      sel_last;

	// Free when nothing is pending or the only pending result leaves now.
	always_comb begin
		out_free = !out_valid || out_ready;
		take     = out_free && (pend_q != 3'b000);
		done     = (pend_q == 3'b000) || (out_free && $onehot(pend_q));
	end

	// Pick the lowest pending result and clear it.
	always_comb begin
		pend_next = pend_q;
		sel_pix   = '0;
		sel_row   = row_s2 - gf3_pkg::ROW_W'(1);
		sel_col   = col_s2;
		sel_last  = 1'b0;
		if (pend_q[0]) begin
			pend_next[0] = 1'b0;
			sel_pix      = interior_s2 ? filt : '0;
			sel_col      = col_s2 - gf3_pkg::COL_W'(1);
		end else if (pend_q[1]) begin
			pend_next[1] = 1'b0;
		end else begin
			pend_next[2] = 1'b0;
			sel_row      = row_s2;
			sel_last     = last_s2;
		end
	end

	// Pending set and job fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'b000;
		end else if (load) begin
			pend_q <= {job_s1.emit_bot, job_s1.emit_edge, job_s1.emit_win};
		end else if (take) begin
			pend_q <= pend_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			interior_s2 <= job_s1.interior;
			last_s2     <= job_s1.last;
			row_s2      <= job_s1.row;
			col_s2      <= job_s1.col;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pixel_out  <= sel_pix;
			out_row    <= sel_row;
			out_col    <= sel_col;
			frame_last <= sel_last;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/gaussian_3x3_image_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_3x3_image_filter: streaming 3x3 Gaussian blur.
// Pixels arrive in raster order; each output is the 1-2-1 / 2-4-2 / 1-2-1
// weighted sum over sixteen, border pixels are zero, tagged with row, column
// and an end-of-frame flag.
//
//   Channel  Signals                                      Direction
//   in       in_valid, in_ready, pixel_in                 into the block
//   out      out_valid, out_ready, pixel_out, out_row,    out of the block
//            out_col, frame_last
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data    into the block
//
// One pixel per cycle is accepted while the emitter keeps up; a pixel goes
// from accept to line-store read, window shift with line-store write-back,
// then the emitter, which sends one result per cycle while the output is not
// stalled. A pixel that releases two or three results (ends of rows, the
// last row) keeps the emitter busy until the last of them is taken and so
// holds off the next pixel at the input; a stalled output
// stalls the input as well. Reset clears the counters, the window and the
// pipeline; the line stores are not cleared. A configuration write restarts
// the frame.
// ----------------------------------------------------------------------------
module gaussian_3x3_image_filter (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire [gf3_pkg::PIX_W-1:0]            pixel_in,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [gf3_pkg::PIX_W-1:0]           pixel_out,
	output logic [gf3_pkg::ROW_W-1:0]           out_row,
	output logic [gf3_pkg::COL_W-1:0]           out_col,
	output logic                                frame_last,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [gf3_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [gf3_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic                       cfg_xfer;
	logic [gf3_pkg::ROW_W-1:0]  hm1_q;
	logic [gf3_pkg::COL_W-1:0]  wm1_q;
	logic [gf3_pkg::HCFG_W-1:0] h_raw;
	logic [gf3_pkg::WCFG_W-1:0] w_raw;
	logic [gf3_pkg::ROW_W-1:0]  row_q;
	logic [gf3_pkg::COL_W-1:0]  col_q;
	logic                       accept;
	logic                       s2_done;
	logic                       s1_adv;
	logic                       s1_valid_q;
	logic [gf3_pkg::PIX_W-1:0]  pix_s1;
	gf3_pkg::job_t              job_s1;
	gf3_pkg::job_t              job;
	logic [gf3_pkg::PIX_W-1:0]  filt;
	logic                       col_end;

	// Configuration: always ready, values stored as size minus one, clamped.
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign h_raw     = cfg_data[gf3_pkg::HCFG_W-1:0];
	assign w_raw     = cfg_data[gf3_pkg::WCFG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hm1_q <= gf3_pkg::ROW_W'(2);
			wm1_q <= gf3_pkg::COL_W'(2);
		end else if (cfg_xfer) begin
			unique case (cfg_index)
				gf3_pkg::CFG_HEIGHT: begin
					if (h_raw < gf3_pkg::HCFG_W'(3)) begin
						hm1_q <= gf3_pkg::ROW_W'(2);
					end else if (h_raw > gf3_pkg::HCFG_W'(gf3_pkg::MAX_HEIGHT)) begin
						hm1_q <= gf3_pkg::ROW_W'(gf3_pkg::MAX_HEIGHT - 1);
					end else begin
						hm1_q <= gf3_pkg::ROW_W'(h_raw - gf3_pkg::HCFG_W'(1));
					end
				end
				gf3_pkg::CFG_WIDTH: begin
					if (w_raw < gf3_pkg::WCFG_W'(3)) begin
						wm1_q <= gf3_pkg::COL_W'(2);
					end else if (w_raw > gf3_pkg::WCFG_W'(gf3_pkg::MAX_WIDTH)) begin
						wm1_q <= gf3_pkg::COL_W'(gf3_pkg::MAX_WIDTH - 1);
					end else begin
						wm1_q <= gf3_pkg::COL_W'(w_raw - gf3_pkg::WCFG_W'(1));
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Input handshake: stage one moves on when the emitter can take its job.
	assign s1_adv   = s1_valid_q && s2_done;
	assign in_ready = !s1_valid_q || s2_done;
	assign accept   = in_valid && in_ready;
	assign col_end  = (col_q == wm1_q);

	// Results this pixel releases, decided from its position.
	always_comb begin
		job.emit_win  = (row_q != '0) && (col_q != '0);
		job.emit_edge = (row_q != '0) && col_end;
		job.emit_bot  = (row_q == hm1_q);
		job.interior  = (row_q >= gf3_pkg::ROW_W'(2)) && (col_q >= gf3_pkg::COL_W'(2));
		job.last      = col_end;
		job.row       = row_q;
		job.col       = col_q;
	end

	// Raster position of the next pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_xfer) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= (row_q == hm1_q) ? '0 : row_q + gf3_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + gf3_pkg::COL_W'(1);
			end
		end
	end

	// Stage one: waits for the line-store read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pixel_in;
			job_s1 <= job;
		end
	end

	gf3_linebuf u_linebuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_q),
		.shift   (s1_adv),
		.wr_addr (job_s1.col),
		.pix_s1  (pix_s1),
		.clear   (cfg_xfer),
		.filt    (filt)
	);

	gf3_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (s1_adv),
		.job_s1     (job_s1),
		.filt       (filt),
		.done       (s2_done),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_last (frame_last)
	);

`ifndef SYNTH
	// The raster position never leaves the configured image.
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= wm1_q) && (row_q <= hm1_q))
		else $error("raster position outside the image");

	// A non-zero result can only be an interior pixel.
	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (pixel_out != '0)) |-> ((out_row != '0) && (out_col != '0)))
		else $error("non-zero result on the top or left border");

	// The end-of-frame result is a border zero.
	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_last) |-> (pixel_out == '0))
		else $error("end-of-frame result is not zero");

	// An accepted pixel always occupies stage one in the next cycle.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted pixel lost before stage one");
`endif

endmodule

`default_nettype wire
